// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tccs_pkg.sv
`default_nettype none

package tccs_pkg;

  localparam int CELL_W = 16;
  localparam int CODE_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int WORD_W = 21;
  localparam int WORD_COL_SHIFT = 10;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam logic FUNC_PRINT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam code_t CODE_FIRST_PRINTABLE = 8'd20;
  localparam code_t CODE_BACKSPACE       = 8'h08;
  localparam code_t CODE_ENTER           = 8'h0d;

endpackage

`default_nettype wire

// File: rtl/tccs_if.sv
`default_nettype none

interface tccs_in_if;
  import tccs_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  cell_t cell_value;
  row_t  read_row;
  col_t  read_col;

  modport source (output valid, func, cell_value, read_row, read_col, input ready);
  modport sink   (input valid, func, cell_value, read_row, read_col, output ready);
endinterface

interface tccs_out_if;
  import tccs_pkg::*;

  logic  valid;
  logic  ready;
  row_t  cursor_row_out;
  col_t  cursor_col_out;
  word_t cursor_word;
  cell_t read_data;
  logic  scrolled;

  modport source (output valid, cursor_row_out, cursor_col_out, cursor_word, read_data,
                  scrolled, input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, cursor_word, read_data,
                  scrolled, output ready);
endinterface

`default_nettype wire

// File: rtl/tccs_screen_ram.sv
`default_nettype none

module tccs_screen_ram #(
  parameter int DEPTH  = 1200,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire                 clk,
  input  wire                 wr_en,
  input  wire  [ADDR_W-1:0]   wr_addr,
  input  tccs_pkg::cell_t     wr_data,
  input  wire  [ADDR_W-1:0]   rd_addr,
  output tccs_pkg::cell_t     rd_data
);
  import tccs_pkg::*;

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_scroll_unit.sv
`default_nettype none

// Text console: a SCREEN_ROWS x SCREEN_COLS screen of 16-bit cells in one
// single-port-write, single-port-read RAM, plus a cursor. Print beats write
// a printable cell at the cursor, step back and clear on backspace (nothing at
// the top left corner), start a new row on enter, and ignore other control
// codes; read beats return one cell (zero when out of range). Every beat gets
// one result with the cursor, its packed word and a scroll flag. After reset
// the RAM is cleared one cell per cycle with in_ch.ready low. A print beat
// that does not scroll forms its result in the pending result register when
// it is taken; a read beat goes through S_READ first (registered RAM read).
// A print beat that scrolls first runs S_SCROLL and S_SCR_END: the shared
// address counter sweeps the RAM, moving each cell up one row and zeroing
// the bottom row, one cell per cycle through the single write port. A
// finished result waits in the pending register until the output register
// is free, and in_ch.ready stays low until it has moved there, so a new beat
// is not taken before the last one's result has left, and later still while
// the output register is full and out_ch.ready is low.
module text_console_cursor_scroll_unit #(
  parameter int SCREEN_COLS = 40,
  parameter int SCREEN_ROWS = 30
) (
  input  wire        clk,
  input  wire        rst_n,
  tccs_in_if.sink    in_ch,
  tccs_out_if.source out_ch
);
  import tccs_pkg::*;

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int MUL_W      = ROW_W + COL_W;

  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_COLS);
  localparam row_t ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
  localparam col_t COL_LAST  = COL_W'(SCREEN_COLS - 1);
  localparam row_t ROW_COUNT = ROW_W'(SCREEN_ROWS);
  localparam col_t COL_COUNT = COL_W'(SCREEN_COLS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_SCROLL  = 3'd3;
  localparam logic [2:0] S_SCR_END = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  row_t              cur_row_r, cur_row_nxt;
  col_t              cur_col_r, cur_col_nxt;

  // copy pipe: the cell read this cycle is written back in the next cycle
  logic              cp_valid_r, cp_valid_nxt;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;
  logic              cp_zero_r, cp_zero_nxt;

  logic              rd_in_range_r, rd_in_range_nxt;

  logic              res_pend_r, res_pend_nxt;
  cell_t             res_data_r, res_data_nxt;
  logic              res_scrolled_r, res_scrolled_nxt;

  logic              out_valid_r, out_valid_nxt;
  row_t              out_row_r;
  col_t              out_col_r;
  cell_t             out_data_r;
  logic              out_scrolled_r;
  logic              out_load;

  logic              in_accept;
  code_t             code;
  logic [MUL_W-1:0]  cur_prod;
  logic [MUL_W-1:0]  rd_prod;
  logic [ADDR_W-1:0] cur_addr;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  cell_t             wr_data;
  logic [ADDR_W-1:0] rd_addr;
  cell_t             rd_data;

  assign in_ch.ready = (state_r == S_IDLE) && !res_pend_r;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign code        = in_ch.cell_value[CODE_W-1:0];

  assign cur_prod = MUL_W'(cur_row_r) * MUL_W'(SCREEN_COLS);
  assign rd_prod  = MUL_W'(in_ch.read_row) * MUL_W'(SCREEN_COLS);
  assign cur_addr = ADDR_W'(cur_prod) + ADDR_W'(cur_col_r);

  tccs_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt        = state_r;
    sweep_nxt        = sweep_r;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    cp_valid_nxt     = 1'b0;
    cp_addr_nxt      = sweep_r;
    cp_zero_nxt      = (sweep_r >= COPY_END);
    rd_in_range_nxt  = rd_in_range_r;
    res_pend_nxt     = res_pend_r;
    res_data_nxt     = res_data_r;
    res_scrolled_nxt = res_scrolled_r;
    wr_en            = 1'b0;
    wr_addr          = cur_addr;
    wr_data          = in_ch.cell_value;
    rd_addr          = ADDR_W'(rd_prod) + ADDR_W'(in_ch.read_col);

    if (out_load) begin
      res_pend_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_r;
        wr_data = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_ch.func == FUNC_READ) begin
            rd_in_range_nxt = (in_ch.read_row < ROW_COUNT) && (in_ch.read_col < COL_COUNT);
            state_nxt       = S_READ;
          end else begin
            if (code >= CODE_FIRST_PRINTABLE) begin
              wr_en = 1'b1;
              if (cur_col_r == COL_LAST) begin
                cur_col_nxt = '0;
                if (cur_row_r == ROW_LAST) begin
                  state_nxt = S_SCROLL;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end else if (code == CODE_BACKSPACE) begin
              // at column zero this lands on the last cell of the row above
              wr_addr = cur_addr - 1'b1;
              wr_data = '0;
              if (cur_col_r != '0) begin
                wr_en       = 1'b1;
                cur_col_nxt = cur_col_r - 1'b1;
              end else if (cur_row_r != '0) begin
                wr_en       = 1'b1;
                cur_row_nxt = cur_row_r - 1'b1;
                cur_col_nxt = COL_LAST;
              end
            end else if (code == CODE_ENTER) begin
              cur_col_nxt = '0;
              if (cur_row_r == ROW_LAST) begin
                state_nxt = S_SCROLL;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end
            if (state_nxt != S_SCROLL) begin
              res_pend_nxt     = 1'b1;
              res_data_nxt     = '0;
              res_scrolled_nxt = 1'b0;
            end
            sweep_nxt = '0;
          end
        end
      end
      S_READ: begin
        res_pend_nxt     = 1'b1;
        res_data_nxt     = rd_in_range_r ? rd_data : '0;
        res_scrolled_nxt = 1'b0;
        state_nxt        = S_IDLE;
      end
      S_SCROLL: begin
        // fetch the cell one row below; bottom row gets zero instead
        rd_addr      = sweep_r + ROW_STEP;
        cp_valid_nxt = 1'b1;
        wr_en        = cp_valid_r;
        wr_addr      = cp_addr_r;
        wr_data      = cp_zero_r ? '0 : rd_data;
        sweep_nxt    = sweep_r + 1'b1;
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          state_nxt = S_SCR_END;
        end
      end
      S_SCR_END: begin
        wr_en            = cp_valid_r;
        wr_addr          = cp_addr_r;
        wr_data          = cp_zero_r ? '0 : rd_data;
        res_pend_nxt     = 1'b1;
        res_data_nxt     = '0;
        res_scrolled_nxt = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
        sweep_nxt = '0;
      end
    endcase
  end

  assign out_load      = res_pend_r && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cp_valid_r  <= 1'b0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cp_valid_r  <= cp_valid_nxt;
      res_pend_r  <= res_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r      <= cp_addr_nxt;
    cp_zero_r      <= cp_zero_nxt;
    rd_in_range_r  <= rd_in_range_nxt;
    res_data_r     <= res_data_nxt;
    res_scrolled_r <= res_scrolled_nxt;
    if (out_load) begin
      // cursor holds while a result is pending, so it matches this beat
      out_row_r      <= cur_row_r;
      out_col_r      <= cur_col_r;
      out_data_r     <= res_data_r;
      out_scrolled_r <= res_scrolled_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_row_out = out_row_r;
  assign out_ch.cursor_col_out = out_col_r;
  assign out_ch.cursor_word    = {out_row_r, out_col_r, {WORD_COL_SHIFT{1'b0}}};
  assign out_ch.read_data      = out_data_r;
  assign out_ch.scrolled       = out_scrolled_r;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_scroll_cursor, clk, rst_n, out_valid_r && out_scrolled_r, (out_row_r == ROW_LAST) && (out_col_r == '0))
  `ASSERT_IMPLY(a_cursor_range, clk, rst_n, state_r != S_CLEAR, (cur_row_r < ROW_COUNT) && (cur_col_r < COL_COUNT))
  `ASSERT_IMPLY(a_scroll_start, clk, rst_n, $rose(state_r == S_SCROLL), $past(in_accept))
  `ASSERT_NEXT(a_read_done, clk, rst_n, state_r == S_READ, res_pend_r && (state_r == S_IDLE))

endmodule

`default_nettype wire

// File: verif/text_console_cursor_scroll_unit_tb.sv
`default_nettype none

module text_console_cursor_scroll_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccs_pkg::*;

  localparam int COLS = 40;
  localparam int ROWS = 30;
  localparam int ROW_SHIFT = 16;
  localparam int RANDOM_BEATS = 700;
  // a scroll sweeps the whole screen, one cell per cycle
  localparam int TAIL_CYCLES = ROWS * COLS + 100;

  typedef struct packed {
    row_t  row;
    col_t  col;
    word_t word;
    cell_t data;
    logic  scrolled;
  } console_result_t;

  logic clk;
  logic rst_n;

  tccs_in_if  in_ch();
  tccs_out_if out_ch();

  text_console_cursor_scroll_unit #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predicted console state
  cell_t screen_img [ROWS*COLS];
  row_t  cur_row;
  col_t  cur_col;

  console_result_t pending_results[$];
  int mismatch_count;
  int beats_sent;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Move to the next row; scroll instead when on the bottom row.
  function automatic logic line_feed();
    if (int'(cur_row) + 1 >= ROWS) begin
      for (int i = 0; i + COLS < ROWS * COLS; i++) screen_img[i] = screen_img[i + COLS];
      for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) screen_img[i] = '0;
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic console_result_t console_step(input logic f, input cell_t cv,
                                                   input row_t r, input col_t k);
    console_result_t res;
    code_t code;
    res = '0;
    code = cv[CODE_W-1:0];
    if (f == FUNC_READ) begin
      if (r < ROWS && k < COLS) res.data = screen_img[r * COLS + k];
    end else if (code >= CODE_FIRST_PRINTABLE) begin
      screen_img[cur_row * COLS + cur_col] = cv;
      if (int'(cur_col) == COLS - 1) begin
        cur_col = '0;
        res.scrolled = line_feed();
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end else if (code == CODE_BACKSPACE) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 1'b1;
        screen_img[cur_row * COLS + cur_col] = '0;
      end else if (cur_row != 0) begin
        cur_row = cur_row - 1'b1;
        cur_col = col_t'(COLS - 1);
        screen_img[cur_row * COLS + cur_col] = '0;
      end
    end else if (code == CODE_ENTER) begin
      cur_col = '0;
      res.scrolled = line_feed();
    end
    res.row  = cur_row;
    res.col  = cur_col;
    res.word = (word_t'(cur_row) << ROW_SHIFT) + (word_t'(cur_col) << WORD_COL_SHIFT);
    return res;
  endfunction

  // Drive one beat from a falling edge; return at the falling edge after acceptance.
  task automatic send_beat(input logic f, input cell_t cv, input row_t r, input col_t k);
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.cell_value <= cv;
    in_ch.read_row   <= r;
    in_ch.read_col   <= k;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(console_step(f, cv, r, k));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic print_code(input cell_t cv);
    send_beat(FUNC_PRINT, cv, row_t'($urandom), col_t'($urandom));
  endtask

  task automatic read_cell(input row_t r, input col_t k);
    send_beat(FUNC_READ, cell_t'($urandom), r, k);
  endtask

  function automatic cell_t random_printable();
    return {8'($urandom_range(0, 255)), 8'($urandom_range(int'(CODE_FIRST_PRINTABLE), 255))};
  endfunction

  // Hold the input idle until every outstanding result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_corner_backspace();
    print_code({8'hab, CODE_BACKSPACE});
    read_cell('0, '0);
  endtask

  task automatic test_print_codes();
    print_code({8'h00, CODE_FIRST_PRINTABLE});
    print_code(16'hffff);
    print_code({8'h5a, CODE_FIRST_PRINTABLE - 8'd1});
    print_code(16'hff00);
    print_code({8'hc3, CODE_ENTER});
    // backspace at column zero crosses to the last column above
    print_code({8'h00, CODE_BACKSPACE});
    print_code(16'h7f41);
    print_code({8'h11, CODE_BACKSPACE});
    print_code({8'h22, CODE_BACKSPACE});
    print_code(16'h8042);
  endtask

  task automatic test_reads();
    read_cell('0, '0);
    read_cell('0, 6'd1);
    read_cell('0, 6'd38);
    read_cell(5'd29, 6'd39);
    read_cell(5'd30, '0);
    read_cell('0, 6'd40);
    read_cell(5'd31, 6'd63);
  endtask

  task automatic test_bottom_scroll();
    for (int i = 0; i < 8; i++) print_code(random_printable());
    while (int'(cur_row) < ROWS - 1) print_code({8'h00, CODE_ENTER});
    for (int i = 0; i < 3; i++) print_code(random_printable());
    print_code({8'h01, CODE_ENTER});
    // fill the bottom row so the wrap scrolls
    for (int i = 0; i < COLS + 2; i++) print_code(random_printable());
    for (int i = 0; i < 4; i++) read_cell(row_t'(ROWS - 2), col_t'(i));
    read_cell(row_t'(ROWS - 1), '0);
    read_cell(row_t'(ROWS - 1), 6'd1);
  endtask

  task automatic test_random_text();
    int stop_at;
    int pick;
    int len;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      no_gaps = (beats_sent > stop_at - 500) && (beats_sent < stop_at - 300);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(0, 45);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) print_code({8'($urandom), CODE_BACKSPACE});
          else print_code(random_printable());
        end
        print_code({8'($urandom), CODE_ENTER});
      end else if (pick < 82) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0) read_cell(row_t'($urandom), col_t'($urandom));
          else read_cell(row_t'($urandom_range(0, ROWS - 1)),
                         col_t'($urandom_range(0, COLS - 1)));
        end
      end else if (pick < 94) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) print_code(cell_t'($urandom));
      end else begin
        len = $urandom_range(1, 50);
        for (int i = 0; i < len; i++) print_code({8'($urandom), CODE_BACKSPACE});
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_row_out", 32'(out_ch.cursor_row_out), 32'(want.row));
        check_field("cursor_col_out", 32'(out_ch.cursor_col_out), 32'(want.col));
        check_field("cursor_word", 32'(out_ch.cursor_word), 32'(want.word));
        check_field("read_data", 32'(out_ch.read_data), 32'(want.data));
        check_field("scrolled", 32'(out_ch.scrolled), 32'(want.scrolled));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PRINT;
    in_ch.cell_value = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    beats_sent = 0;
    no_gaps = 1'b0;
    foreach (screen_img[i]) screen_img[i] = '0;
    cur_row = '0;
    cur_col = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_backspace();
    test_print_codes();
    test_reads();
    wait_drained();
    test_bottom_scroll();
    wait_drained();
    test_random_text();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
